// ----- src/ppdg_pkg.sv -----
// ppdg_pkg: shared types and constants for the packet pacing delay generator
// word formats, operation codes, register map, reset values, sequencer states
// no dependencies
`default_nettype none

package ppdg_pkg;

   // register map
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 32;

   localparam logic [CsrIndexWidth-1:0] REG_PACING_MODE   = 3'd0;
   localparam logic [CsrIndexWidth-1:0] REG_INTERVAL      = 3'd1;
   localparam logic [CsrIndexWidth-1:0] REG_BURST_LEN     = 3'd2;
   localparam logic [CsrIndexWidth-1:0] REG_BURST_GAP     = 3'd3;
   localparam logic [CsrIndexWidth-1:0] REG_BACKOFF_BASE  = 3'd4;
   localparam logic [CsrIndexWidth-1:0] REG_RETRY_LIMIT   = 3'd5;
   localparam logic [CsrIndexWidth-1:0] REG_CYCLES_PER_US = 3'd6;

   // reset values
   localparam logic [31:0] ResetInterval     = 32'd1000000;
   localparam logic [15:0] ResetBurstSize    = 16'd10;
   localparam logic [31:0] ResetBurstGap     = 32'd5000000;
   localparam logic [31:0] ResetBackoffBase  = 32'd100000;
   localparam logic [4:0]  ResetRetryLimit   = 5'd5;
   localparam logic [15:0] ResetCyclesPerUs  = 16'd1000;

   // command queue between front and back
   localparam int unsigned QueueDepth      = 2;
   localparam int unsigned QueuePtrWidth   = $clog2(QueueDepth);
   localparam int unsigned QueueCountWidth = $clog2(QueueDepth + 1);

   // serial divider
   localparam int unsigned DivSteps      = 64;
   localparam int unsigned DivCountWidth = $clog2(DivSteps + 1);

   typedef enum logic [1:0] {
      MODE_CONTINUOUS = 2'd0,
      MODE_BURST      = 2'd1,
      MODE_RATE_LIMIT = 2'd2,
      MODE_BACKOFF    = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      OP_CLEAR   = 3'd0,
      OP_FIXED   = 3'd1,
      OP_BURST   = 3'd2,
      OP_RATE    = 3'd3,
      OP_BACKOFF = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_FETCH  = 2'd0,
      ST_DIVIDE = 2'd1,
      ST_FINISH = 2'd2
   } state_type;

   typedef struct packed {
      logic        kind;
      logic [63:0] now_cycles;
   } req_type;

   typedef struct packed {
      logic [31:0] delay_us;
      logic        burst_gap;
      logic        retries_exhausted;
   } rsp_type;

   typedef struct packed {
      op_type      op;
      logic [63:0] now_cycles;
   } entry_type;

   typedef struct packed {
      mode_type    pacing_mode;
      logic [31:0] packet_interval_us;
      logic [15:0] packets_per_burst;
      logic [31:0] burst_gap_us;
      logic [31:0] backoff_base_us;
      logic [4:0]  retry_limit;
      logic [15:0] cycles_per_microsecond;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// ----- src/ppdg_front.sv -----
// ppdg_front: accepts request words, classifies them into operations and
// holds them in a short queue for the back end
// depends on ppdg_pkg
`default_nettype none

module ppdg_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire ppdg_pkg::req_type     req_payload,
   input  wire ppdg_pkg::mode_type    pacing_mode,
   input  wire logic                  pop,
   output logic                       entry_valid,
   output ppdg_pkg::entry_type        entry
);

   logic [ppdg_pkg::QueueCountWidth-1:0] count_ff, count_in;
   logic [ppdg_pkg::QueuePtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [ppdg_pkg::QueuePtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   ppdg_pkg::entry_type                  queue_ff [ppdg_pkg::QueueDepth];
   ppdg_pkg::entry_type                  classified;
   logic                                 push;
   logic                                 do_pop;

   assign req_stall   = (count_ff == ppdg_pkg::QueueCountWidth'(ppdg_pkg::QueueDepth));
   assign push        = req_valid && !req_stall;
   assign entry_valid = (count_ff != '0);
   assign do_pop      = pop && entry_valid;
   assign entry       = queue_ff[rd_ptr_ff];

   // operation decode
   always_comb begin
      classified.now_cycles = req_payload.now_cycles;
      if (req_payload.kind) begin
         classified.op = ppdg_pkg::OP_CLEAR;
      end else begin
         unique case (pacing_mode)
            ppdg_pkg::MODE_CONTINUOUS: classified.op = ppdg_pkg::OP_FIXED;
            ppdg_pkg::MODE_BURST:      classified.op = ppdg_pkg::OP_BURST;
            ppdg_pkg::MODE_RATE_LIMIT: classified.op = ppdg_pkg::OP_RATE;
            ppdg_pkg::MODE_BACKOFF:    classified.op = ppdg_pkg::OP_BACKOFF;
            default:                   classified.op = ppdg_pkg::OP_FIXED;
         endcase
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == ppdg_pkg::QueuePtrWidth'(ppdg_pkg::QueueDepth - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == ppdg_pkg::QueuePtrWidth'(ppdg_pkg::QueueDepth - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

`default_nettype wire

// ----- src/ppdg_div.sv -----
// ppdg_div: restoring divider, 64-bit dividend by 16-bit divisor, one
// quotient bit per cycle; a zero divisor divides by one
// depends on ppdg_pkg
`default_nettype none

module ppdg_div (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [63:0]         dividend,
   input  wire logic [15:0]         divisor,
   output ppdg_pkg::div_status_type status,
   output logic [63:0]              quotient
);

   logic [ppdg_pkg::DivCountWidth-1:0] count_ff, count_in;
   logic                               done_ff, done_in;
   logic [63:0]                        quot_ff, quot_in;
   logic [15:0]                        rem_ff, rem_in;
   logic [15:0]                        divisor_ff, divisor_in;
   logic [16:0]                        partial;
   logic [16:0]                        reduced;
   logic                               fits;

   assign partial = {rem_ff, quot_ff[63]};
   assign reduced = partial - {1'b0, divisor_ff};
   assign fits    = (partial >= {1'b0, divisor_ff});

   always_comb begin
      count_in   = count_ff;
      done_in    = 1'b0;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         count_in   = ppdg_pkg::DivCountWidth'(ppdg_pkg::DivSteps);
         quot_in    = dividend;
         rem_in     = '0;
         divisor_in = (divisor == '0) ? 16'd1 : divisor;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == ppdg_pkg::DivCountWidth'(1));
         quot_in  = {quot_ff[62:0], fits};
         rem_in   = fits ? reduced[15:0] : partial[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign status.busy = (count_ff != '0);
   assign status.done = done_ff;
   assign quotient    = quot_ff;

endmodule

`default_nettype wire

// ----- src/ppdg_back.sv -----
// ppdg_back: executes queued operations, keeps the burst/retry position and
// the previous send stamp, and drives the result register
// depends on ppdg_pkg; the divide unit sits beside it in the top level
`default_nettype none

module ppdg_back #(
   parameter int unsigned DELAY_WIDTH = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire ppdg_pkg::cfg_type          cfg,
   input  wire logic                       entry_valid,
   input  wire ppdg_pkg::entry_type        entry,
   output logic                            pop,
   output logic                            div_start,
   output logic [63:0]                     div_dividend,
   output logic [15:0]                     div_divisor,
   input  wire ppdg_pkg::div_status_type   div_status,
   input  wire logic [63:0]                div_quotient,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output ppdg_pkg::rsp_type               rsp_payload
);

   localparam logic [63:0] DelayMax =
      (DELAY_WIDTH >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << DELAY_WIDTH) - 64'd1);

   ppdg_pkg::state_type state_ff, state_in;
   logic [15:0]         position_ff, position_in;
   logic [63:0]         prev_ff, prev_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ppdg_pkg::rsp_type   rsp_ff, rsp_in;

   logic                slot_free;
   logic                needs_divide;
   logic                load;
   ppdg_pkg::rsp_type   fetch_rsp;
   logic [15:0]         fetch_position;
   logic [15:0]         burst_len;
   logic [16:0]         burst_next;
   logic [63:0]         shifted;
   logic                saturated;
   logic [31:0]         backoff_delay;
   logic [31:0]         rate_delay;

   assign slot_free    = !rsp_valid_ff || !rsp_stall;
   assign needs_divide = (entry.op == ppdg_pkg::OP_RATE) && (prev_ff != '0);
   assign div_dividend = entry.now_cycles - prev_ff;
   assign div_divisor  = cfg.cycles_per_microsecond;

   assign burst_len     = (cfg.packets_per_burst == '0) ? 16'd1 : cfg.packets_per_burst;
   assign burst_next    = {1'b0, position_ff} + 17'd1;
   assign shifted       = {32'd0, cfg.backoff_base_us} << position_ff[4:0];
   assign saturated     = |(shifted & ~DelayMax);
   assign backoff_delay = saturated ? DelayMax[31:0] : shifted[31:0];
   assign rate_delay    = (div_quotient < {32'd0, cfg.packet_interval_us})
                          ? cfg.packet_interval_us - div_quotient[31:0] : 32'd0;

   // result of an operation that does not use the divider
   always_comb begin
      fetch_rsp      = '0;
      fetch_position = position_ff;
      unique case (entry.op)
         ppdg_pkg::OP_CLEAR: begin
            fetch_position = '0;
         end
         ppdg_pkg::OP_FIXED: begin
            fetch_rsp.delay_us = cfg.packet_interval_us;
         end
         ppdg_pkg::OP_BURST: begin
            if (burst_next >= {1'b0, burst_len}) begin
               fetch_position      = '0;
               fetch_rsp.delay_us  = cfg.burst_gap_us;
               fetch_rsp.burst_gap = 1'b1;
            end else begin
               fetch_position     = burst_next[15:0];
               fetch_rsp.delay_us = cfg.packet_interval_us;
            end
         end
         ppdg_pkg::OP_RATE: begin
            // first packet: nothing to wait for
            fetch_rsp.delay_us = 32'd0;
         end
         ppdg_pkg::OP_BACKOFF: begin
            if (position_ff < {11'd0, cfg.retry_limit}) begin
               fetch_position     = position_ff + 16'd1;
               fetch_rsp.delay_us = backoff_delay;
            end else begin
               fetch_position              = '0;
               fetch_rsp.delay_us          = cfg.backoff_base_us;
               fetch_rsp.retries_exhausted = 1'b1;
            end
         end
         default: begin
            fetch_rsp = '0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ppdg_pkg::ST_FETCH: begin
            if (entry_valid && needs_divide) begin
               state_in = ppdg_pkg::ST_DIVIDE;
            end
         end
         ppdg_pkg::ST_DIVIDE: begin
            if (div_status.done) begin
               state_in = ppdg_pkg::ST_FINISH;
            end
         end
         ppdg_pkg::ST_FINISH: begin
            if (slot_free) begin
               state_in = ppdg_pkg::ST_FETCH;
            end
         end
         default: begin
            state_in = ppdg_pkg::ST_FETCH;
         end
      endcase
   end

   // outputs and datapath updates
   always_comb begin
      pop         = 1'b0;
      div_start   = 1'b0;
      load        = 1'b0;
      rsp_in      = rsp_ff;
      position_in = position_ff;
      prev_in     = prev_ff;
      unique case (state_ff)
         ppdg_pkg::ST_FETCH: begin
            if (entry_valid && (needs_divide || slot_free)) begin
               pop         = 1'b1;
               div_start   = needs_divide;
               load        = !needs_divide;
               rsp_in      = fetch_rsp;
               position_in = fetch_position;
               prev_in     = (entry.op == ppdg_pkg::OP_CLEAR) ? 64'd0 : entry.now_cycles;
            end
         end
         ppdg_pkg::ST_FINISH: begin
            if (slot_free) begin
               load   = 1'b1;
               rsp_in = '{delay_us: rate_delay, burst_gap: 1'b0, retries_exhausted: 1'b0};
            end
         end
         default: begin
         end
      endcase
      priority if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppdg_pkg::ST_FETCH;
         position_ff  <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         position_ff  <= position_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ----- src/packet_pacing_delay_generator.sv -----
// packet_pacing_delay_generator: top level with register file, front queue,
// back end sequencer and serial divider
// depends on ppdg_pkg, ppdg_front, ppdg_back, ppdg_div
//
// For each request word (a packet send with its cycle stamp, or a pacing
// reset) the block returns one response word with the delay in microseconds
// for the current mode: continuous, burst, rate limited or exponential
// backoff. Requests enter a two-word queue and are executed one at a time.
// Continuous, burst, backoff, pacing reset and the first rate limited packet
// go from the fetch state straight to the response register. A rate limited
// send after an earlier send converts elapsed cycles to microseconds in a
// bit-serial 64-bit divider. The user must write registers through the csr
// port only while no request is in flight; the block does not enforce this.
`default_nettype none

module packet_pacing_delay_generator #(
   parameter int unsigned DELAY_WIDTH = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire ppdg_pkg::req_type                    req_payload,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output ppdg_pkg::rsp_type                         rsp_payload,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [ppdg_pkg::CsrIndexWidth-1:0]   csr_index,
   input  wire logic [ppdg_pkg::CsrDataWidth-1:0]    csr_wdata
);

   ppdg_pkg::cfg_type        cfg_ff, cfg_in;
   logic                     pop;
   logic                     entry_valid;
   ppdg_pkg::entry_type      entry;
   logic                     div_start;
   logic [63:0]              div_dividend;
   logic [15:0]              div_divisor;
   ppdg_pkg::div_status_type div_status;
   logic [63:0]              div_quotient;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ppdg_pkg::REG_PACING_MODE:
               cfg_in.pacing_mode = ppdg_pkg::mode_type'(csr_wdata[1:0]);
            ppdg_pkg::REG_INTERVAL:      cfg_in.packet_interval_us     = csr_wdata;
            ppdg_pkg::REG_BURST_LEN:     cfg_in.packets_per_burst      = csr_wdata[15:0];
            ppdg_pkg::REG_BURST_GAP:     cfg_in.burst_gap_us           = csr_wdata;
            ppdg_pkg::REG_BACKOFF_BASE:  cfg_in.backoff_base_us        = csr_wdata;
            ppdg_pkg::REG_RETRY_LIMIT:   cfg_in.retry_limit            = csr_wdata[4:0];
            ppdg_pkg::REG_CYCLES_PER_US: cfg_in.cycles_per_microsecond = csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pacing_mode            <= ppdg_pkg::MODE_CONTINUOUS;
         cfg_ff.packet_interval_us     <= ppdg_pkg::ResetInterval;
         cfg_ff.packets_per_burst      <= ppdg_pkg::ResetBurstSize;
         cfg_ff.burst_gap_us           <= ppdg_pkg::ResetBurstGap;
         cfg_ff.backoff_base_us        <= ppdg_pkg::ResetBackoffBase;
         cfg_ff.retry_limit            <= ppdg_pkg::ResetRetryLimit;
         cfg_ff.cycles_per_microsecond <= ppdg_pkg::ResetCyclesPerUs;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ppdg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .pacing_mode (cfg_ff.pacing_mode),
      .pop         (pop),
      .entry_valid (entry_valid),
      .entry       (entry)
   );

   ppdg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_status),
      .quotient (div_quotient)
   );

   ppdg_back #(
      .DELAY_WIDTH (DELAY_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .entry_valid  (entry_valid),
      .entry        (entry),
      .pop          (pop),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_status   (div_status),
      .div_quotient (div_quotient),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload)
   );

   // the two flags come from different modes
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.burst_gap && rsp_payload.retries_exhausted))
      else $error("burst gap and retries exhausted in one word");

   a_gap_delay: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.burst_gap) |-> (rsp_payload.delay_us == cfg_ff.burst_gap_us))
      else $error("burst gap word without burst gap delay");

   a_restart_delay: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.retries_exhausted)
         |-> (rsp_payload.delay_us == cfg_ff.backoff_base_us))
      else $error("backoff restart word without base delay");

   a_divider_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider restarted while busy");

   a_reset_clears_rsp: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

`default_nettype wire
